// ===== rtl/core/fcrwl_pkg.sv =====
// Shared types, constants and helper functions for the four-class lock unit.
package fcrwl_pkg;

  // Holder counter width and the default per-class holder limits
  localparam int CntW           = 8;
  localparam int MaxReaders     = 255;
  localparam int MaxSoftReaders = 255;
  localparam int MaxWriters     = 255;
  localparam int MaxSoftWriters = 255;
  localparam int NumKinds       = 4;

  // Request queue between front and back; depth must be a power of two
  localparam int QueueDepth = 2;

  // Request codes
  typedef enum logic [1:0] {
    REQ_LOCK    = 2'd0,
    REQ_UNLOCK  = 2'd1,
    REQ_UPGRADE = 2'd2,
    REQ_QUERY   = 2'd3
  } req_e;

  // Lock classes
  typedef enum logic [1:0] {
    KIND_READ       = 2'd0,
    KIND_SOFT_READ  = 2'd1,
    KIND_WRITE      = 2'd2,
    KIND_SOFT_WRITE = 2'd3
  } kind_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_REFUSED = 2'd1,
    ST_RANGE   = 2'd2
  } status_e;

  // Decoded request as it travels from front to back
  typedef struct packed {
    req_e                  req;
    logic [NumKinds-1:0]   kind_oh;
    logic [NumKinds-1:0]   tgt_oh;
    logic                  same_kind;
  } cmd_t;

  typedef logic [CntW-1:0] cnt_t;

  // Cap a configured limit at what the counter can hold
  function automatic cnt_t cap_limit(int lim);
    cnt_t res;
    if (lim > (2 ** CntW) - 1) begin
      res = '1;
    end else begin
      res = cnt_t'(lim);
    end
    return res;
  endfunction

  // Per-class grant check given which classes are held by others
  function automatic logic [NumKinds-1:0] compat_vec(logic [NumKinds-1:0] busy);
    logic [NumKinds-1:0] res;
    res[KIND_READ]       = !busy[KIND_WRITE] && !busy[KIND_SOFT_WRITE];
    res[KIND_SOFT_READ]  = !busy[KIND_WRITE];
    res[KIND_WRITE]      = !(|busy);
    res[KIND_SOFT_WRITE] = !busy[KIND_WRITE] && !busy[KIND_READ];
    return res;
  endfunction

endpackage

// ===== rtl/core/fcrwl_front.sv =====
// Front end: takes requests and decodes them into one-hot class commands.
module fcrwl_front (
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           req_type_i,
  input  logic [1:0]           lock_kind_i,
  input  logic [1:0]           target_kind_i,
  output logic                 push_o,
  output fcrwl_pkg::cmd_t      cmd_o,
  input  logic                 queue_full_i
);

  // Accept whenever the queue has room
  assign in_ready_o = !queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i;

  // Decode the request fields into one-hot class masks
  always_comb begin
    cmd_o.req       = fcrwl_pkg::req_e'(req_type_i);
    cmd_o.kind_oh   = fcrwl_pkg::NumKinds'(1) << lock_kind_i;
    cmd_o.tgt_oh    = fcrwl_pkg::NumKinds'(1) << target_kind_i;
    cmd_o.same_kind = (lock_kind_i == target_kind_i);
  end

endmodule

// ===== rtl/core/fcrwl_queue.sv =====
// Short command queue that decouples the front end from the back end.
module fcrwl_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  fcrwl_pkg::cmd_t  cmd_i,
  output logic             full_o,
  output logic             valid_o,
  output fcrwl_pkg::cmd_t  cmd_o,
  input  logic             pop_i
);

  localparam int PtrW = (fcrwl_pkg::QueueDepth > 1) ? $clog2(fcrwl_pkg::QueueDepth) : 1;
  localparam int CntQW = $clog2(fcrwl_pkg::QueueDepth + 1);

  fcrwl_pkg::cmd_t   mem_q [fcrwl_pkg::QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntQW-1:0]  fill_q, fill_d;
  logic              do_push, do_pop;

  assign full_o  = (fill_q == CntQW'(fcrwl_pkg::QueueDepth));
  assign valid_o = (fill_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + CntQW'(1);
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - CntQW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Store the entry
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== rtl/core/fcrwl_back.sv =====
// Back end: applies grant rules, updates holder counts and registers the result.
module fcrwl_back #(
  parameter int MaxReaders     = fcrwl_pkg::MaxReaders,
  parameter int MaxSoftReaders = fcrwl_pkg::MaxSoftReaders,
  parameter int MaxWriters     = fcrwl_pkg::MaxWriters,
  parameter int MaxSoftWriters = fcrwl_pkg::MaxSoftWriters
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cmd_valid_i,
  input  fcrwl_pkg::cmd_t              cmd_i,
  output logic                         cmd_pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   status_o,
  output logic                         holds_o,
  output logic [fcrwl_pkg::CntW-1:0]   reader_total_o,
  output logic [fcrwl_pkg::CntW-1:0]   soft_reader_total_o,
  output logic [fcrwl_pkg::CntW-1:0]   writer_total_o,
  output logic [fcrwl_pkg::CntW-1:0]   soft_writer_total_o
);

  localparam int NK = fcrwl_pkg::NumKinds;
  localparam int CW = fcrwl_pkg::CntW;

  // Holder limits, capped at what the counters can hold
  localparam fcrwl_pkg::cnt_t LimRead      = fcrwl_pkg::cap_limit(MaxReaders);
  localparam fcrwl_pkg::cnt_t LimSoftRead  = fcrwl_pkg::cap_limit(MaxSoftReaders);
  localparam fcrwl_pkg::cnt_t LimWrite     = fcrwl_pkg::cap_limit(MaxWriters);
  localparam fcrwl_pkg::cnt_t LimSoftWrite = fcrwl_pkg::cap_limit(MaxSoftWriters);

  fcrwl_pkg::cnt_t   limits [NK];
  fcrwl_pkg::cnt_t   cnt_q [NK];
  fcrwl_pkg::cnt_t   cnt_d [NK];
  logic [NK-1:0]     busy, busy_ign, at_lim, inc, dec;
  fcrwl_pkg::cnt_t   kind_cnt, tgt_cnt, tgt_lim, tgt_after;
  fcrwl_pkg::status_e st_d, status_q;
  logic              holds_d, holds_q;
  logic              out_valid_q, fire;

  assign limits[fcrwl_pkg::KIND_READ]       = LimRead;
  assign limits[fcrwl_pkg::KIND_SOFT_READ]  = LimSoftRead;
  assign limits[fcrwl_pkg::KIND_WRITE]      = LimWrite;
  assign limits[fcrwl_pkg::KIND_SOFT_WRITE] = LimSoftWrite;

  // Take a command whenever the result register is free or being drained
  assign fire      = cmd_valid_i && (!out_valid_q || out_ready_i);
  assign cmd_pop_o = fire;

  // Per-class flags and selected counts
  always_comb begin
    kind_cnt = '0;
    tgt_cnt  = '0;
    tgt_lim  = '0;
    for (int k = 0; k < NK; k++) begin
      busy[k]     = (cnt_q[k] != '0);
      busy_ign[k] = (cnt_q[k] > {{(CW-1){1'b0}}, cmd_i.kind_oh[k]});
      at_lim[k]   = (cnt_q[k] >= limits[k]);
      kind_cnt    = kind_cnt | (cnt_q[k] & {CW{cmd_i.kind_oh[k]}});
      tgt_cnt     = tgt_cnt  | (cnt_q[k] & {CW{cmd_i.tgt_oh[k]}});
      tgt_lim     = tgt_lim  | (limits[k] & {CW{cmd_i.tgt_oh[k]}});
    end
    tgt_after = tgt_cnt - {{(CW-1){1'b0}}, cmd_i.same_kind};
  end

  // Decide the outcome of the request
  always_comb begin
    st_d    = fcrwl_pkg::ST_OK;
    holds_d = 1'b0;
    inc     = '0;
    dec     = '0;
    case (cmd_i.req)
      fcrwl_pkg::REQ_LOCK: begin
        if (!(|(fcrwl_pkg::compat_vec(busy) & cmd_i.kind_oh))) begin
          st_d = fcrwl_pkg::ST_REFUSED;
        end else if (|(at_lim & cmd_i.kind_oh)) begin
          st_d = fcrwl_pkg::ST_RANGE;
        end else begin
          inc = cmd_i.kind_oh;
        end
      end
      fcrwl_pkg::REQ_UNLOCK: begin
        if (kind_cnt == '0) begin
          st_d = fcrwl_pkg::ST_RANGE;
        end else begin
          dec = cmd_i.kind_oh;
        end
      end
      fcrwl_pkg::REQ_UPGRADE: begin
        if (kind_cnt == '0) begin
          st_d = fcrwl_pkg::ST_RANGE;
        end else if (!(|(fcrwl_pkg::compat_vec(busy_ign) & cmd_i.tgt_oh))) begin
          st_d = fcrwl_pkg::ST_REFUSED;
        end else if (tgt_after >= tgt_lim) begin
          st_d = fcrwl_pkg::ST_RANGE;
        end else begin
          inc = cmd_i.tgt_oh;
          dec = cmd_i.kind_oh;
        end
      end
      fcrwl_pkg::REQ_QUERY: begin
        holds_d = (kind_cnt != '0);
      end
      default: begin
        st_d = fcrwl_pkg::ST_OK;
      end
    endcase
  end

  // Apply the count changes
  always_comb begin
    for (int k = 0; k < NK; k++) begin
      cnt_d[k] = cnt_q[k] + {{(CW-1){1'b0}}, inc[k]} - {{(CW-1){1'b0}}, dec[k]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      for (int k = 0; k < NK; k++) begin
        cnt_q[k] <= '0;
      end
    end else begin
      if (fire) begin
        out_valid_q <= 1'b1;
        for (int k = 0; k < NK; k++) begin
          cnt_q[k] <= cnt_d[k];
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q <= st_d;
      holds_q  <= holds_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign status_o            = status_q;
  assign holds_o             = holds_q;
  assign reader_total_o      = cnt_q[fcrwl_pkg::KIND_READ];
  assign soft_reader_total_o = cnt_q[fcrwl_pkg::KIND_SOFT_READ];
  assign writer_total_o      = cnt_q[fcrwl_pkg::KIND_WRITE];
  assign soft_writer_total_o = cnt_q[fcrwl_pkg::KIND_SOFT_WRITE];

endmodule

// ===== rtl/core/four_class_rw_lock_unit.sv =====
// Four-class lock unit: holder counts for read, soft read, write and soft write
// locks. Every request is a try and gets exactly one result. The unit sustains
// one request per cycle while results are taken: the front end decodes a
// request into a two-entry queue, and the back end resolves the head of the
// queue combinationally against the four counters and writes the outcome into
// the result register, so a request passes through the queue entry and then
// the result register before its result shows. The result register and the
// queue absorb output stalls, so requests are still taken while a result waits,
// until the queue is full. The totals reported with each result are the counts after that request.
module four_class_rw_lock_unit #(
  parameter int MaxReaders     = fcrwl_pkg::MaxReaders,
  parameter int MaxSoftReaders = fcrwl_pkg::MaxSoftReaders,
  parameter int MaxWriters     = fcrwl_pkg::MaxWriters,
  parameter int MaxSoftWriters = fcrwl_pkg::MaxSoftWriters
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  req_type_i,
  input  logic [1:0]                  lock_kind_i,
  input  logic [1:0]                  target_kind_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  status_o,
  output logic                        holds_o,
  output logic [fcrwl_pkg::CntW-1:0]  reader_total_o,
  output logic [fcrwl_pkg::CntW-1:0]  soft_reader_total_o,
  output logic [fcrwl_pkg::CntW-1:0]  writer_total_o,
  output logic [fcrwl_pkg::CntW-1:0]  soft_writer_total_o
);

  logic             push, queue_full, queue_valid, pop;
  fcrwl_pkg::cmd_t  front_cmd, head_cmd;

  fcrwl_front u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .lock_kind_i   (lock_kind_i),
    .target_kind_i (target_kind_i),
    .push_o        (push),
    .cmd_o         (front_cmd),
    .queue_full_i  (queue_full)
  );

  fcrwl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (queue_full),
    .valid_o (queue_valid),
    .cmd_o   (head_cmd),
    .pop_i   (pop)
  );

  fcrwl_back #(
    .MaxReaders     (MaxReaders),
    .MaxSoftReaders (MaxSoftReaders),
    .MaxWriters     (MaxWriters),
    .MaxSoftWriters (MaxSoftWriters)
  ) u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_valid_i         (queue_valid),
    .cmd_i               (head_cmd),
    .cmd_pop_o           (pop),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .status_o            (status_o),
    .holds_o             (holds_o),
    .reader_total_o      (reader_total_o),
    .soft_reader_total_o (soft_reader_total_o),
    .writer_total_o      (writer_total_o),
    .soft_writer_total_o (soft_writer_total_o)
  );

endmodule

// ===== rtl/core/fcrwl_checker.sv =====
// Port-level checker for the four-class lock unit, with its bind statement.
module fcrwl_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [1:0]                  status_o,
  input logic                        holds_o,
  input logic [fcrwl_pkg::CntW-1:0]  reader_total_o,
  input logic [fcrwl_pkg::CntW-1:0]  soft_reader_total_o,
  input logic [fcrwl_pkg::CntW-1:0]  writer_total_o,
  input logic [fcrwl_pkg::CntW-1:0]  soft_writer_total_o
);

  // A stalled result holds its status, hold flag and reader and writer totals
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(holds_o)
      && $stable(reader_total_o) && $stable(writer_total_o))
  else $error("stalled result changed");

  // A writer excludes every other holder
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (writer_total_o != '0) |-> (reader_total_o == '0)
      && (soft_reader_total_o == '0) && (soft_writer_total_o == '0))
  else $error("writer held alongside other holders");

  // Readers and soft writers never coexist
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (reader_total_o != '0) |-> (soft_writer_total_o == '0))
  else $error("reader held alongside soft writer");

  // A hold is reported only with status OK, and status is a legal code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o != 2'd3) && (!holds_o || status_o == fcrwl_pkg::ST_OK))
  else $error("bad status or hold flag");

endmodule

bind four_class_rw_lock_unit fcrwl_checker u_fcrwl_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .out_valid_o         (out_valid_o),
  .out_ready_i         (out_ready_i),
  .status_o            (status_o),
  .holds_o             (holds_o),
  .reader_total_o      (reader_total_o),
  .soft_reader_total_o (soft_reader_total_o),
  .writer_total_o      (writer_total_o),
  .soft_writer_total_o (soft_writer_total_o)
);

// ===== verif/fcrwl_lock_checker.sv =====
`timescale 1ns / 100ps
// Lock unit checker: tracks holder counts, predicts each result and compares on transfer.
module fcrwl_lock_checker
  import fcrwl_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic [1:0]       req_type_i,
  input  logic [1:0]       lock_kind_i,
  input  logic [1:0]       target_kind_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic [1:0]       status_i,
  input  logic             holds_i,
  input  logic [CntW-1:0]  reader_total_i,
  input  logic [CntW-1:0]  soft_reader_total_i,
  input  logic [CntW-1:0]  writer_total_i,
  input  logic [CntW-1:0]  soft_writer_total_i,
  output int               mismatch_count_o,
  output int               pending_count_o,
  output int               request_count_o,
  output int               result_count_o,
  output int               refused_count_o,
  output int               range_count_o,
  output int               peak_holders_o
);

  // One lock result as the unit reports it
  typedef struct packed {
    status_e status;
    logic    holds;
    cnt_t    readers;
    cnt_t    soft_readers;
    cnt_t    writers;
    cnt_t    soft_writers;
  } lock_outcome_t;

  cnt_t          holders [NumKinds];
  lock_outcome_t awaited_outcomes [$];
  int            mismatches = 0;
  int            requests   = 0;
  int            results    = 0;
  int            refusals   = 0;
  int            range_hits = 0;
  int            peak       = 0;

  // Per-class holder limit, capped by the counter width
  function automatic cnt_t class_cap(kind_e k);
    int lim;
    case (k)
      KIND_READ:      lim = MaxReaders;
      KIND_SOFT_READ: lim = MaxSoftReaders;
      KIND_WRITE:     lim = MaxWriters;
      default:        lim = MaxSoftWriters;
    endcase
    if (lim > (1 << CntW) - 1) begin
      lim = (1 << CntW) - 1;
    end
    return cnt_t'(lim);
  endfunction

  // Grant rule for one class, given which classes other requesters hold
  function automatic logic grant_ok(kind_e want, logic [NumKinds-1:0] held);
    logic ok;
    case (want)
      KIND_READ:      ok = !held[KIND_WRITE] && !held[KIND_SOFT_WRITE];
      KIND_SOFT_READ: ok = !held[KIND_WRITE];
      KIND_WRITE:     ok = (held == '0);
      default:        ok = !held[KIND_WRITE] && !held[KIND_READ];
    endcase
    return ok;
  endfunction

  // Apply one request to the holder counts and build its result
  function automatic lock_outcome_t resolve_request(req_e req, kind_e kind, kind_e tgt);
    logic [NumKinds-1:0] held;
    lock_outcome_t       res;
    cnt_t                tgt_after_drop;
    int                  i;
    res        = '0;
    res.status = ST_OK;
    case (req)
      REQ_LOCK: begin
        for (i = 0; i < NumKinds; i++) begin
          held[i] = (holders[i] != 0);
        end
        if (!grant_ok(kind, held)) begin
          res.status = ST_REFUSED;
        end else if (holders[kind] >= class_cap(kind)) begin
          res.status = ST_RANGE;
        end else begin
          holders[kind] = holders[kind] + 1'b1;
        end
      end
      REQ_UNLOCK: begin
        if (holders[kind] == 0) begin
          res.status = ST_RANGE;
        end else begin
          holders[kind] = holders[kind] - 1'b1;
        end
      end
      REQ_UPGRADE: begin
        if (holders[kind] == 0) begin
          res.status = ST_RANGE;
        end else begin
          // Ignore the requester's own hold of the source class
          for (i = 0; i < NumKinds; i++) begin
            held[i] = (int'(holders[i]) > ((i == int'(kind)) ? 1 : 0));
          end
          tgt_after_drop = (tgt == kind) ? holders[tgt] - 1'b1 : holders[tgt];
          if (!grant_ok(tgt, held)) begin
            res.status = ST_REFUSED;
          end else if (tgt_after_drop >= class_cap(tgt)) begin
            res.status = ST_RANGE;
          end else begin
            holders[kind] = holders[kind] - 1'b1;
            holders[tgt]  = holders[tgt] + 1'b1;
          end
        end
      end
      default: begin
        res.holds = (holders[kind] != 0);
      end
    endcase
    res.readers      = holders[KIND_READ];
    res.soft_readers = holders[KIND_SOFT_READ];
    res.writers      = holders[KIND_WRITE];
    res.soft_writers = holders[KIND_SOFT_WRITE];
    return res;
  endfunction

  // Compare results first, then record the request taken at the same edge
  always @(posedge clk_i) begin
    lock_outcome_t seen;
    lock_outcome_t want;
    if (!rst_ni) begin
      foreach (holders[k]) begin
        holders[k] = '0;
      end
      awaited_outcomes.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        results++;
        seen.status       = status_e'(status_i);
        seen.holds        = holds_i;
        seen.readers      = reader_total_i;
        seen.soft_readers = soft_reader_total_i;
        seen.writers      = writer_total_i;
        seen.soft_writers = soft_writer_total_i;
        if (awaited_outcomes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result %0d arrived with nothing outstanding", $realtime, results);
          end
        end else begin
          want = awaited_outcomes.pop_front();
          if (seen !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: result %0d expected status %0d holds %0b totals %0d/%0d/%0d/%0d",
                       $realtime, results, want.status, want.holds, want.readers,
                       want.soft_readers, want.writers, want.soft_writers);
              $display("%0t: result %0d got      status %0d holds %0b totals %0d/%0d/%0d/%0d",
                       $realtime, results, status_i, holds_i, reader_total_i,
                       soft_reader_total_i, writer_total_i, soft_writer_total_i);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        requests++;
        want = resolve_request(req_e'(req_type_i), kind_e'(lock_kind_i),
                               kind_e'(target_kind_i));
        if (want.status == ST_REFUSED) begin
          refusals++;
        end else if (want.status == ST_RANGE) begin
          range_hits++;
        end
        foreach (holders[k]) begin
          if (int'(holders[k]) > peak) begin
            peak = int'(holders[k]);
          end
        end
        awaited_outcomes.push_back(want);
      end
    end
    mismatch_count_o <= mismatches;
    pending_count_o  <= awaited_outcomes.size();
    request_count_o  <= requests;
    result_count_o   <= results;
    refused_count_o  <= refusals;
    range_count_o    <= range_hits;
    peak_holders_o   <= peak;
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// Top-level bench for the four-class lock unit: clock, reset, request traffic and verdict.
module testbench;
  import fcrwl_pkg::*;

  localparam int HoldOffCycles = 60;
  localparam int DrainCycles   = 10;
  localparam int SettleLimit   = 5000;

  // Traffic shapes for the random part
  typedef enum int {
    MIX_FILL_READ,
    MIX_CHURN,
    MIX_DRAIN,
    MIX_FILL_SOFT_WRITE
  } traffic_mix_e;

  logic            clk           = 1'b0;
  logic            rst_n         = 1'b0;
  logic            in_valid      = 1'b0;
  logic            in_ready;
  logic [1:0]      req_type      = REQ_QUERY;
  logic [1:0]      lock_kind     = KIND_READ;
  logic [1:0]      target_kind   = KIND_READ;
  logic            out_valid;
  logic            out_ready     = 1'b0;
  logic [1:0]      status;
  logic            holds;
  logic [CntW-1:0] reader_total;
  logic [CntW-1:0] soft_reader_total;
  logic [CntW-1:0] writer_total;
  logic [CntW-1:0] soft_writer_total;

  logic hold_off_go   = 1'b0;
  logic quiet_stretch = 1'b0;

  int mismatches;
  int pending;
  int requests;
  int results;
  int refusals;
  int range_hits;
  int peak;

  always #10 clk = ~clk;

  four_class_rw_lock_unit u_dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .req_type_i          (req_type),
    .lock_kind_i         (lock_kind),
    .target_kind_i       (target_kind),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .status_o            (status),
    .holds_o             (holds),
    .reader_total_o      (reader_total),
    .soft_reader_total_o (soft_reader_total),
    .writer_total_o      (writer_total),
    .soft_writer_total_o (soft_writer_total)
  );

  fcrwl_lock_checker u_checker (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_ready_i          (in_ready),
    .req_type_i          (req_type),
    .lock_kind_i         (lock_kind),
    .target_kind_i       (target_kind),
    .out_valid_i         (out_valid),
    .out_ready_i         (out_ready),
    .status_i            (status),
    .holds_i             (holds),
    .reader_total_i      (reader_total),
    .soft_reader_total_i (soft_reader_total),
    .writer_total_i      (writer_total),
    .soft_writer_total_i (soft_writer_total),
    .mismatch_count_o    (mismatches),
    .pending_count_o     (pending),
    .request_count_o     (requests),
    .result_count_o      (results),
    .refused_count_o     (refusals),
    .range_count_o       (range_hits),
    .peak_holders_o      (peak)
  );

  // Offer one request, with random idle cycles ahead of it, and hold it until transfer
  task automatic send_request(req_e req, kind_e kind, kind_e tgt);
    while (!quiet_stretch && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= req;
    lock_kind   <= kind;
    target_kind <= tgt;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
  endtask

  // Draw a request shaped by the traffic mix; the remainder is fully random
  task automatic send_mixed(traffic_mix_e mix);
    int    roll;
    req_e  req;
    kind_e kind;
    kind_e tgt;
    roll = $urandom_range(99);
    req  = req_e'($urandom_range(3));
    kind = kind_e'($urandom_range(3));
    tgt  = kind_e'($urandom_range(3));
    case (mix)
      MIX_FILL_READ: begin
        if (roll < 84) begin
          req = REQ_LOCK; kind = KIND_READ;
        end else if (roll < 90) begin
          req = REQ_LOCK; kind = KIND_SOFT_READ;
        end
      end
      MIX_DRAIN: begin
        if (roll < 86) begin
          req = REQ_UNLOCK; kind = KIND_READ;
        end else if (roll < 92) begin
          req = REQ_UNLOCK; kind = KIND_SOFT_READ;
        end else if (roll < 94) begin
          req = REQ_UNLOCK; kind = KIND_WRITE;
        end
      end
      MIX_FILL_SOFT_WRITE: begin
        if (roll < 78) begin
          req = REQ_LOCK; kind = KIND_SOFT_WRITE;
        end else if (roll < 84) begin
          req = REQ_LOCK; kind = KIND_SOFT_READ;
        end else if (roll < 90) begin
          req = REQ_UPGRADE; kind = KIND_SOFT_READ; tgt = KIND_SOFT_WRITE;
        end else if (roll < 92) begin
          req = REQ_UNLOCK; kind = KIND_WRITE;
        end
      end
      default: begin
      end
    endcase
    send_request(req, kind, tgt);
  endtask

  // Result side: random back-pressure, one long hold-off, quiet during the churn stretch
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off_go && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
      end
      out_ready <= quiet_stretch || ($urandom_range(99) >= 24);
    end
  end

  // Request traffic and verdict
  initial begin
    int settle;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty unit, exclusive writer, class conflicts, upgrades, free-class errors
    send_request(REQ_QUERY,   KIND_READ,       KIND_READ);
    send_request(REQ_UNLOCK,  KIND_READ,       KIND_READ);
    send_request(REQ_UPGRADE, KIND_READ,       KIND_WRITE);
    send_request(REQ_LOCK,    KIND_WRITE,      KIND_READ);
    send_request(REQ_QUERY,   KIND_WRITE,      KIND_SOFT_WRITE);
    send_request(REQ_LOCK,    KIND_READ,       KIND_READ);
    send_request(REQ_LOCK,    KIND_SOFT_READ,  KIND_READ);
    send_request(REQ_LOCK,    KIND_SOFT_WRITE, KIND_READ);
    send_request(REQ_LOCK,    KIND_WRITE,      KIND_READ);
    send_request(REQ_UPGRADE, KIND_WRITE,      KIND_WRITE);
    send_request(REQ_UPGRADE, KIND_WRITE,      KIND_READ);
    send_request(REQ_LOCK,    KIND_SOFT_READ,  KIND_READ);
    send_request(REQ_LOCK,    KIND_SOFT_WRITE, KIND_READ);
    send_request(REQ_UPGRADE, KIND_READ,       KIND_WRITE);
    send_request(REQ_UPGRADE, KIND_SOFT_READ,  KIND_SOFT_WRITE);
    send_request(REQ_UNLOCK,  KIND_READ,       KIND_READ);
    send_request(REQ_UPGRADE, KIND_SOFT_READ,  KIND_SOFT_WRITE);
    send_request(REQ_LOCK,    KIND_SOFT_READ,  KIND_READ);
    send_request(REQ_LOCK,    KIND_READ,       KIND_READ);
    send_request(REQ_UPGRADE, KIND_SOFT_WRITE, KIND_WRITE);
    send_request(REQ_UNLOCK,  KIND_SOFT_READ,  KIND_READ);
    send_request(REQ_UPGRADE, KIND_SOFT_WRITE, KIND_WRITE);
    send_request(REQ_QUERY,   KIND_SOFT_WRITE, KIND_READ);
    send_request(REQ_UNLOCK,  KIND_WRITE,      KIND_READ);
    send_request(REQ_UNLOCK,  KIND_SOFT_WRITE, KIND_READ);

    // Push readers past the limit; stall the result side early to back up the queue
    for (int n = 0; n < 360; n++) begin
      if (n == 100) begin
        hold_off_go <= 1'b1;
      end
      send_mixed(MIX_FILL_READ);
    end

    // Churn at the limit with no idling on either side
    quiet_stretch <= 1'b1;
    repeat (60) send_mixed(MIX_CHURN);
    quiet_stretch <= 1'b0;

    // Release everything, then drive soft writers to the limit
    repeat (340) send_mixed(MIX_DRAIN);
    repeat (360) send_mixed(MIX_FILL_SOFT_WRITE);
    repeat (40) send_mixed(MIX_CHURN);
    in_valid <= 1'b0;

    // Wait for outstanding results, then let the pipeline settle
    @(posedge clk);
    settle = 0;
    while (pending != 0 && settle < SettleLimit) begin
      @(posedge clk);
      settle++;
    end
    repeat (DrainCycles) @(posedge clk);

    $display("Covered %0d requests and %0d results: %0d refused, %0d out of range,",
             requests, results, refusals, range_hits);
    $display("peak holder count %0d, %0d mismatches, %0d results outstanding",
             peak, mismatches, pending);
    if (mismatches == 0 && pending == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("testbench failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/fcrwl_pkg.sv
rtl/core/fcrwl_front.sv
rtl/core/fcrwl_queue.sv
rtl/core/fcrwl_back.sv
rtl/core/four_class_rw_lock_unit.sv
rtl/core/fcrwl_checker.sv
verif/fcrwl_lock_checker.sv
verif/testbench.sv
